// ===== rtl/core/nops_pkg.sv =====
// ----------------------------------------------------------------------------
// nops_pkg
// shared constants, command codes and the cordic arctangent table
// ----------------------------------------------------------------------------
package nops_pkg;

    localparam int MAX_BODIES_DEF = 16;
    localparam int TRIG_BITS_DEF  = 16;

    // cordic gain compensation 0.60725293 in q4.30
    localparam logic [33:0] GAIN_Q30 = 34'd652032874;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // atan(2^-i) in q0.32 turns
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/nops_if.sv =====
// ----------------------------------------------------------------------------
// nops channel interfaces
// valid/ready channels for commands in and nearest-body results out
// ----------------------------------------------------------------------------
interface nops_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [3:0]         entry_index;
    logic [31:0]        start_phase;
    logic [31:0]        phase_rate;
    logic [23:0]        radius;
    logic [31:0]        time_now;
    logic signed [25:0] query_x;
    logic signed [25:0] query_y;

    modport source (output valid, command, entry_index, start_phase, phase_rate,
                    radius, time_now, query_x, query_y, input ready);
    modport sink   (input valid, command, entry_index, start_phase, phase_rate,
                    radius, time_now, query_x, query_y, output ready);
endinterface

interface nops_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         nearest_index;
    logic signed [25:0] nearest_x;
    logic signed [25:0] nearest_y;

    modport source (output valid, nearest_index, nearest_x, nearest_y, input ready);
    modport sink   (input valid, nearest_index, nearest_x, nearest_y, output ready);
endinterface

// ===== rtl/core/nops_ram.sv =====
// ----------------------------------------------------------------------------
// nops_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nops_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/nearest_orbiting_point_search.sv =====
// ----------------------------------------------------------------------------
// nearest_orbiting_point_search
// body table in one ram; a query places each active body by cordic and keeps
// the nearest one to the query point
// ----------------------------------------------------------------------------
// load: written to the table when taken, no result
// query: one result after all counted bodies, count = active bodies capped at MAX_BODIES;
//   each body walks ram read, angle multiply, TRIG_BITS serial cordic steps,
//   radius scale, square and compare; one query at a time
// next item is taken while a result waits in the output register
// reset (synchronous, active low) clears control and active_bodies; table is not cleared
module nearest_orbiting_point_search #(
    parameter int MAX_BODIES = nops_pkg::MAX_BODIES_DEF,
    parameter int TRIG_BITS  = nops_pkg::TRIG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    nops_in_if.sink     i_in,
    nops_out_if.source  o_out
);
    import nops_pkg::*;

    localparam int AW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW  = $clog2(MAX_BODIES + 1);
    localparam int SW  = $clog2(TRIG_BITS);
    localparam int DW  = 88;
    localparam int CVW = TRIG_BITS + 4;
    localparam int PW  = TRIG_BITS + 29;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_ANGLE, S_ROT, S_SCALE, S_SQUARE, S_CMP, S_DONE
    } t_state;

    t_state               r_state;
    logic [4:0]           r_active;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_idx;
    logic [SW-1:0]        r_step;
    logic [31:0]          r_time;
    logic signed [25:0]   r_qx, r_qy;
    logic [23:0]          r_radius;
    logic [1:0]           r_quad;
    logic signed [33:0]   r_x, r_y, r_z;
    logic signed [25:0]   r_px, r_py;
    logic [53:0]          r_dx2, r_dy2;
    logic                 r_found;
    logic [54:0]          r_best_d;
    logic [AW-1:0]        r_best;
    logic signed [25:0]   r_best_x, r_best_y;
    logic                 r_out_valid;
    logic [3:0]           r_out_idx;
    logic signed [25:0]   r_out_x, r_out_y;

    logic                 in_xfer, ram_we, out_load;
    logic [DW-1:0]        rdata;
    logic [31:0]          angle;
    logic signed [33:0]   sx, sy, atan_s, n_x, n_y, n_z;
    logic signed [33:0]   c, s;
    logic signed [CVW-1:0] cv, sv;
    logic signed [PW-1:0] prod_x, prod_y;
    logic signed [26:0]   dx, dy;
    logic signed [53:0]   sqx, sqy;
    logic [54:0]          sum_sq;
    logic [CW-1:0]        count;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign ram_we     = in_xfer && (i_in.command == CMD_LOAD)
                        && (32'(i_in.entry_index) < MAX_BODIES);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    nops_ram #(.WIDTH(DW), .DEPTH(MAX_BODIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata ({i_in.start_phase, i_in.phase_rate, i_in.radius}),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        count = (32'(r_active) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(r_active);
        angle = rdata[87:56] + 32'(r_time * rdata[55:24]);

        // one cordic rotation step
        sx     = r_y >>> r_step;
        sy     = r_x >>> r_step;
        atan_s = signed'({2'b00, atan_turns(5'(r_step))});
        if (r_z >= 0) begin
            n_x = r_x - sx;
            n_y = r_y + sy;
            n_z = r_z - atan_s;
        end else begin
            n_x = r_x + sx;
            n_y = r_y - sy;
            n_z = r_z + atan_s;
        end

        // quadrant fold back
        case (r_quad)
            2'd0:    begin c = r_x;  s = r_y;  end
            2'd1:    begin c = -r_y; s = r_x;  end
            2'd2:    begin c = -r_x; s = -r_y; end
            default: begin c = r_y;  s = -r_x; end
        endcase
        cv = c[33:30-TRIG_BITS];
        sv = s[33:30-TRIG_BITS];
        prod_x = signed'({1'b0, r_radius}) * cv + (PW'(1) <<< (TRIG_BITS - 1));
        prod_y = signed'({1'b0, r_radius}) * sv + (PW'(1) <<< (TRIG_BITS - 1));

        dx     = {r_px[25], r_px} - {r_qx[25], r_qx};
        dy     = {r_py[25], r_py} - {r_qy[25], r_qy};
        sqx    = dx * dx;
        sqy    = dy * dy;
        sum_sq = {1'b0, r_dx2} + {1'b0, r_dy2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_in.command == CMD_QUERY) begin
                        r_time   <= i_in.time_now;
                        r_qx     <= i_in.query_x;
                        r_qy     <= i_in.query_y;
                        r_count  <= count;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_best   <= '0;
                        r_best_x <= '0;
                        r_best_y <= '0;
                        r_state  <= (count == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_ANGLE;
                end
                S_ANGLE: begin
                    r_radius <= rdata[23:0];
                    r_quad   <= angle[31:30];
                    r_x      <= GAIN_Q30;
                    r_y      <= '0;
                    r_z      <= signed'({4'b0000, angle[29:0]});
                    r_step   <= '0;
                    r_state  <= S_ROT;
                end
                S_ROT: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    if (r_step == SW'(TRIG_BITS - 1)) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SCALE: begin
                    r_px    <= prod_x[TRIG_BITS+25:TRIG_BITS];
                    r_py    <= prod_y[TRIG_BITS+25:TRIG_BITS];
                    r_state <= S_SQUARE;
                end
                S_SQUARE: begin
                    r_dx2   <= unsigned'(sqx);
                    r_dy2   <= unsigned'(sqy);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // strict compare keeps the lowest index on a tie
                    if (!r_found || sum_sq < r_best_d) begin
                        r_found  <= 1'b1;
                        r_best_d <= sum_sq;
                        r_best   <= r_idx;
                        r_best_x <= r_px;
                        r_best_y <= r_py;
                    end
                    if (32'(r_idx) + 1 == 32'(r_count)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_idx   <= 4'(r_best);
                        r_out_x     <= r_best_x;
                        r_out_y     <= r_best_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.nearest_index = r_out_idx;
    assign o_out.nearest_x     = r_out_x;
    assign o_out.nearest_y     = r_out_y;

endmodule

// ===== tb/tb_nearest_orbiting_point_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_orbiting_point_search
// drives load and query transfers with bursty valid and a stalling receiver,
// predicts each nearest body with a cordic placement of its own, or takes a
// given hit for typed rows, and compares every result field by field
// ----------------------------------------------------------------------------
module tb_nearest_orbiting_point_search;
    import nops_pkg::*;

    localparam int N_BODIES   = 16;
    localparam int N_RANDOM   = 1350;
    localparam int QUERY_LAT  = 2 + N_BODIES * (TRIG_BITS_DEF + 5);
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 3000;
    localparam int HOLD_AT    = 300;
    localparam int N_ROWS     = 24;
    localparam int NO_CFG     = -1;

    typedef struct {
        t_cmd               cmd;
        logic [3:0]         idx;
        logic [31:0]        phase;
        logic [31:0]        rate;
        logic [23:0]        rad;
        logic [31:0]        tnow;
        logic signed [25:0] qx;
        logic signed [25:0] qy;
    } t_order;

    typedef struct {
        logic [3:0]  idx;
        logic [25:0] x;
        logic [25:0] y;
    } t_hit;

    typedef struct {
        int     cfg;
        t_order it;
        bit     typed;
        t_hit   hit;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [4:0] i_cfg_data;

    nops_in_if  in_ch ();
    nops_out_if out_ch ();

    nearest_orbiting_point_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state
    logic [31:0] phase_mem [N_BODIES];
    logic [31:0] rate_mem [N_BODIES];
    logic [23:0] radius_mem [N_BODIES];
    logic [4:0]  body_count;

    const logic [31:0] arc_turns [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    t_hit hits_pending [$];
    t_row rows [N_ROWS];
    int   errors = 0;
    int   results_seen = 0;
    int   idle_cycles = 0;
    int   hold_left = 0;
    bit   hold_done = 0;
    int   stall_mode = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void place_body(input logic [31:0] ang, input logic [23:0] rad,
                                       output longint px, output longint py);
        longint x, y, z, dx, dy, c, s, cv, sv;
        x = 652032874;
        y = 0;
        z = longint'(ang[29:0]);
        for (int i = 0; i < TRIG_BITS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(arc_turns[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(arc_turns[i]);
            end
        end
        case (ang[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cv = c >>> (30 - TRIG_BITS_DEF);
        sv = s >>> (30 - TRIG_BITS_DEF);
        px = (longint'(rad) * cv + (longint'(1) << (TRIG_BITS_DEF - 1))) >>> TRIG_BITS_DEF;
        py = (longint'(rad) * sv + (longint'(1) << (TRIG_BITS_DEF - 1))) >>> TRIG_BITS_DEF;
    endfunction

    // returns 1 and the nearest body for a query, 0 for a load
    function automatic bit nearest_body(input t_order it, output t_hit hit);
        int n;
        longint px, py, dx, dy, d, best_d;
        logic [31:0] ang;
        hit = '{idx: 4'd0, x: 26'd0, y: 26'd0};
        if (it.cmd == CMD_LOAD) begin
            phase_mem[it.idx] = it.phase;
            rate_mem[it.idx] = it.rate;
            radius_mem[it.idx] = it.rad;
            return 1'b0;
        end
        n = (body_count > N_BODIES) ? N_BODIES : body_count;
        best_d = 0;
        for (int i = 0; i < n; i++) begin
            ang = phase_mem[i] + it.tnow * rate_mem[i];
            place_body(ang, radius_mem[i], px, py);
            dx = px - longint'(it.qx);
            dy = py - longint'(it.qy);
            d = dx * dx + dy * dy;
            // strict compare keeps the lowest index on ties
            if (i == 0 || d < best_d) begin
                best_d = d;
                hit.idx = i[3:0];
                hit.x = px[25:0];
                hit.y = py[25:0];
            end
        end
        return 1'b1;
    endfunction

    task automatic offer(input t_order it, input bit typed, input t_hit typed_hit);
        t_hit h;
        in_ch.valid       <= 1'b1;
        in_ch.command     <= it.cmd;
        in_ch.entry_index <= it.idx;
        in_ch.start_phase <= it.phase;
        in_ch.phase_rate  <= it.rate;
        in_ch.radius      <= it.rad;
        in_ch.time_now    <= it.tnow;
        in_ch.query_x     <= it.qx;
        in_ch.query_y     <= it.qy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (nearest_body(it, h)) hits_pending.push_back(typed ? typed_hit : h);
    endtask

    task automatic set_bodies(input logic [4:0] val);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (QUERY_LAT + 20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        body_count = val;
    endtask

    function automatic t_order blank_order();
        t_order it;
        it = '{cmd: CMD_QUERY, idx: 4'd0, phase: 32'd0, rate: 32'd0, rad: 24'd0,
               tnow: 32'd0, qx: 26'sd0, qy: 26'sd0};
        return it;
    endfunction

    function automatic t_order random_order();
        t_order it;
        int k;
        it = blank_order();
        it.cmd = ($urandom_range(0, 9) < 3) ? CMD_LOAD : CMD_QUERY;
        it.idx = 4'($urandom);
        it.phase = $urandom;
        k = $urandom_range(0, 9);
        it.rate = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFFFFFF : $urandom;
        k = $urandom_range(0, 9);
        it.rad = (k == 0) ? 24'd0 : (k == 1) ? 24'hFFFFFF :
                 (k < 5) ? 24'($urandom_range(0, 4000)) : 24'($urandom);
        it.tnow = $urandom;
        k = $urandom_range(0, 9);
        if (k < 4) begin
            // points near the orbits make the choice of body a close call
            it.qx = 26'($signed($urandom_range(0, 8000)) - 4000);
            it.qy = 26'($signed($urandom_range(0, 8000)) - 4000);
        end else begin
            it.qx = 26'($urandom);
            it.qy = 26'($urandom);
        end
        return it;
    endfunction

    function automatic void fill_rows();
        t_hit none;
        none = '{idx: 4'd0, x: 26'd0, y: 26'd0};
        foreach (rows[r]) rows[r] = '{cfg: NO_CFG, it: blank_order(), typed: 0, hit: none};
        // no active bodies after reset
        rows[0].it.qx = 26'h1FFFFFF;
        rows[0].it.qy = 26'h2000000;
        rows[0].typed = 1;
        rows[1].it.cmd = CMD_LOAD;
        rows[2].it.cmd = CMD_LOAD;
        rows[2].it.idx = 4'd1;
        rows[2].it.rad = 24'hFFFFFF;
        // body 0 sits on the origin
        rows[3].cfg = 2;
        rows[3].typed = 1;
        rows[4].it.tnow = 32'hFFFFFFFF;
        rows[4].it.qx = 26'h1FFFFFF;
        rows[4].it.qy = 26'h1FFFFFF;
        rows[5].it.cmd = CMD_LOAD;
        rows[5].it.idx = 4'd15;
        rows[5].it.phase = 32'hFFFFFFFF;
        rows[5].it.rate = 32'hFFFFFFFF;
        rows[5].it.rad = 24'hFFFFFF;
        for (int i = 2; i < 15; i++) begin
            rows[i + 4].it.cmd = CMD_LOAD;
            rows[i + 4].it.idx = i[3:0];
            rows[i + 4].it.phase = 32'(i) << 28;
            rows[i + 4].it.rate = 32'h01000000 * i;
            rows[i + 4].it.rad = 24'(1000 * i);
        end
        // entries 2 and 3 identical so a query near them ties
        rows[7].it.phase = 32'h20000000;
        rows[7].it.rate = 32'h02000000;
        rows[7].it.rad = 24'd2000;
        rows[19].cfg = 16;
        rows[19].it.qx = 26'sd2000;
        rows[20].it.tnow = 32'd1;
        rows[20].it.qx = 26'h2000000;
        rows[20].it.qy = 26'h2000000;
        rows[21].cfg = 31;
        rows[21].it.tnow = 32'h80000000;
        rows[22].cfg = 1;
        rows[22].it.qx = 26'sd5;
        rows[23].cfg = 17;
        rows[23].it.tnow = 32'd12345;
        rows[23].it.qy = 26'h1FFFFFF;
    endfunction

    // receiver: checks each transfer and stalls on its own pattern
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (hits_pending.size() == 0) begin
                $error("result with nothing expected: index %0d", out_ch.nearest_index);
                errors++;
            end else begin
                want = hits_pending.pop_front();
                if (out_ch.nearest_index !== want.idx) begin
                    $error("nearest_index expected %0d got %0d", want.idx,
                           out_ch.nearest_index);
                    errors++;
                end
                if (out_ch.nearest_x !== want.x) begin
                    $error("nearest_x expected %0d got %0d", $signed(want.x),
                           out_ch.nearest_x);
                    errors++;
                end
                if (out_ch.nearest_y !== want.y) begin
                    $error("nearest_y expected %0d got %0d", $signed(want.y),
                           out_ch.nearest_y);
                    errors++;
                end
            end
        end
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
        if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= ($urandom_range(0, 7) == 0);
                default: out_ch.ready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_order it;
        t_hit none;
        int burst;
        none = '{idx: 4'd0, x: 26'd0, y: 26'd0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 5'd0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.entry_index = 4'd0;
        in_ch.start_phase = 32'd0;
        in_ch.phase_rate = 32'd0;
        in_ch.radius = 24'd0;
        in_ch.time_now = 32'd0;
        in_ch.query_x = 26'sd0;
        in_ch.query_y = 26'sd0;
        out_ch.ready = 1'b0;
        body_count = 5'd0;
        foreach (phase_mem[i]) begin
            phase_mem[i] = 32'd0;
            rate_mem[i] = 32'd0;
            radius_mem[i] = 24'd0;
        end
        fill_rows();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].cfg != NO_CFG) set_bodies(5'(rows[r].cfg));
            offer(rows[r].it, rows[r].typed, rows[r].hit);
            if ($urandom_range(0, 2) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end

        // every entry is loaded by now, so any count is safe
        burst = $urandom_range(1, 20);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 150 == 75) begin
                case ($urandom_range(0, 5))
                    0: set_bodies(5'd0);
                    1: set_bodies(5'd1);
                    2: set_bodies(5'd16);
                    3: set_bodies(5'd31);
                    default: set_bodies(5'($urandom_range(0, 31)));
                endcase
            end
            it = random_order();
            offer(it, 1'b0, none);
            if (--burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (QUERY_LAT + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== nearest_orbiting_point_search.f =====
rtl/core/nops_pkg.sv
rtl/core/nops_if.sv
rtl/core/nops_ram.sv
rtl/core/nearest_orbiting_point_search.sv
tb/tb_nearest_orbiting_point_search.sv
